// ===== rtl/kth_ancestor_jump_table_defines.svh =====
// assertion macros used by the checker file
`ifndef KTH_ANCESTOR_JUMP_TABLE_DEFINES_SVH
`define KTH_ANCESTOR_JUMP_TABLE_DEFINES_SVH

// consequence checked in the same cycle as the antecedent
`define KAJT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequence checked in the cycle after the antecedent
`define KAJT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/kajt_pkg.sv =====
// shared types and constants for the k-th ancestor jump table
package kajt_pkg;

  localparam int FIELD_W    = 10;
  localparam int KIND_W     = 2;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 16;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_QUERY  = 2'd2
  } kind_t;

  typedef enum logic [4:0] {
    ST_INIT  = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_ADD   = 5'b00100,
    ST_QUERY = 5'b01000,
    ST_FIN   = 5'b10000
  } state_t;

endpackage

// ===== rtl/kth_ancestor_jump_table.sv =====
// k-th ancestor jump table (binary lifting) over a rooted forest
//
// Input stream s_axis: tuser carries the kind (add leaf, remove, query),
// tdata carries node, parent and distance. Output stream m_axis carries
// the ancestor, one transaction per query; add and remove give none.
// Items are handled one at a time. An add does one jump memory write per
// level, each level read from the row found at the level below, so the
// dependent reads of the jump memory set the pace. A query takes one step
// per distance bit, then a result step. Remove and ignored items are done
// when taken. After reset the present flags are cleared by a pass over
// all NODES entries during which s_axis_tready stays low. The jump memory
// is not cleared. A finished result waits in the output register; the
// next item is taken meanwhile, and only a second query stalls at its
// result step until the receiver takes the first.
module kth_ancestor_jump_table #(
  parameter int NODES  = 1024,
  parameter int LEVELS = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // node[9:0], parent[19:10], distance[29:20], zero pad
  input  logic [1:0]  s_axis_tuser,  // kind[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // ancestor[9:0], zero pad
);

  localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int LW = $clog2(LEVELS);
  localparam int FW = kajt_pkg::FIELD_W;

  kajt_pkg::state_t state;

  logic [FW-1:0] in_node;
  logic [FW-1:0] in_parent;
  logic [FW-1:0] in_dist;
  logic          s_fire;
  logic          node_ok;
  logic          far;
  logic [NW-1:0] node_idx;
  logic [NW-1:0] parent_c;

  logic [NW-1:0] node_r;
  logic [LW-1:0] lvl;
  logic [NW-1:0] cur;
  logic          pend;
  logic [LEVELS-1:0] dist_r;
  logic          ok;
  logic          pres;
  logic          pres_q;
  logic [NW-1:0] clr_idx;

  logic [NW-1:0] qc;
  logic [FW-1:0] answer;
  logic          out_free;

  logic          present_mem [NODES];

  logic          jw_en;
  logic [NW-1:0] jw_node;
  logic [LW-1:0] jw_lvl;
  logic [NW-1:0] jw_data;
  logic          jr_en;
  logic [NW-1:0] jr_node;
  logic [LW-1:0] jr_lvl;
  logic [NW-1:0] jd;

  logic [FW-1:0] out_anc;
  logic          out_valid;

  assign in_node   = s_axis_tdata[9:0];
  assign in_parent = s_axis_tdata[19:10];
  assign in_dist   = s_axis_tdata[29:20];

  assign s_axis_tready = (state == kajt_pkg::ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  assign node_ok  = (in_node != '0) && (32'(in_node) < NODES);
  assign node_idx = NW'(in_node);
  assign parent_c = (32'(in_parent) < NODES) ? NW'(in_parent) : '0;
  assign far      = ((32'(in_dist) >> LEVELS) != 32'd0);

  // current climb position: last read result if a jump was taken
  assign qc       = pend ? jd : cur;
  assign answer   = (ok && pres) ? FW'(qc) : '0;
  assign out_free = !out_valid || m_axis_tready;

  kajt_jump_mem #(
    .NW (NW),
    .LW (LW)
  ) u_jump_mem (
    .clk     (clk),
    .wr_en   (jw_en),
    .wr_node (jw_node),
    .wr_lvl  (jw_lvl),
    .wr_data (jw_data),
    .rd_en   (jr_en),
    .rd_node (jr_node),
    .rd_lvl  (jr_lvl),
    .rd_data (jd)
  );

  always_comb begin
    jw_en   = 1'b0;
    jw_node = node_r;
    jw_lvl  = lvl;
    jw_data = jd;
    jr_en   = 1'b0;
    jr_node = jd;
    jr_lvl  = lvl;
    case (state)
      kajt_pkg::ST_IDLE: begin
        // level 0 of an add: parent written and its row read at once
        if (s_fire && (s_axis_tuser == kajt_pkg::KIND_ADD) && node_ok) begin
          jw_en   = 1'b1;
          jw_node = node_idx;
          jw_lvl  = '0;
          jw_data = parent_c;
          jr_en   = 1'b1;
          jr_node = parent_c;
          jr_lvl  = '0;
        end
      end
      kajt_pkg::ST_ADD: begin
        jw_en = 1'b1;
        jr_en = 1'b1;
      end
      kajt_pkg::ST_QUERY: begin
        jr_en   = dist_r[0];
        jr_node = qc;
      end
      default: begin
      end
    endcase
  end

  // present flags: clearing pass, set by add, cleared by remove, read by query
  always_ff @(posedge clk) begin
    if (state == kajt_pkg::ST_INIT) begin
      present_mem[clr_idx] <= 1'b0;
    end else if (s_fire && node_ok) begin
      if (s_axis_tuser == kajt_pkg::KIND_ADD) begin
        present_mem[node_idx] <= 1'b1;
      end else if (s_axis_tuser == kajt_pkg::KIND_REMOVE) begin
        present_mem[node_idx] <= 1'b0;
      end
    end
    if (s_fire) begin
      pres_q <= present_mem[node_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= kajt_pkg::ST_INIT;
      clr_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      if ((state == kajt_pkg::ST_FIN) && out_free) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        kajt_pkg::ST_INIT: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == NW'(NODES - 1)) begin
            state <= kajt_pkg::ST_IDLE;
          end
        end
        kajt_pkg::ST_IDLE: begin
          if (s_fire) begin
            if ((s_axis_tuser == kajt_pkg::KIND_ADD) && node_ok) begin
              state <= kajt_pkg::ST_ADD;
            end else if (s_axis_tuser == kajt_pkg::KIND_QUERY) begin
              state <= kajt_pkg::ST_QUERY;
            end
          end
        end
        kajt_pkg::ST_ADD: begin
          if (lvl == LW'(LEVELS - 1)) begin
            state <= kajt_pkg::ST_IDLE;
          end
        end
        kajt_pkg::ST_QUERY: begin
          if (lvl == LW'(LEVELS - 1)) begin
            state <= kajt_pkg::ST_FIN;
          end
        end
        kajt_pkg::ST_FIN: begin
          if (out_free) begin
            state <= kajt_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= kajt_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      kajt_pkg::ST_IDLE: begin
        if (s_fire) begin
          node_r <= node_idx;
          cur    <= node_idx;
          pend   <= 1'b0;
          dist_r <= LEVELS'(in_dist);
          ok     <= node_ok && !far;
          lvl    <= (s_axis_tuser == kajt_pkg::KIND_ADD) ? LW'(1) : '0;
        end
      end
      kajt_pkg::ST_ADD: begin
        lvl <= lvl + 1'b1;
      end
      kajt_pkg::ST_QUERY: begin
        if (lvl == '0) begin
          pres <= pres_q;
        end
        cur    <= qc;
        pend   <= dist_r[0];
        dist_r <= dist_r >> 1;
        lvl    <= lvl + 1'b1;
      end
      kajt_pkg::ST_FIN: begin
        cur  <= qc;
        pend <= 1'b0;
        if (out_free) begin
          out_anc <= answer;
        end
      end
      default: begin
      end
    endcase
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {(kajt_pkg::OUT_DATA_W - FW)'(0), out_anc};

endmodule

// ===== rtl/kajt_jump_mem.sv =====
// jump table memory: one write and one read port, row zero masking, write forwarding
module kajt_jump_mem #(
  parameter int NW = 10,
  parameter int LW = 4
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [NW-1:0] wr_node,
  input  logic [LW-1:0] wr_lvl,
  input  logic [NW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [NW-1:0] rd_node,
  input  logic [LW-1:0] rd_lvl,
  output logic [NW-1:0] rd_data
);

  localparam int DEPTH = 2 ** (NW + LW);

  logic [NW-1:0] mem [DEPTH];
  logic [NW-1:0] q;
  logic          zero;
  logic          fwd;
  logic [NW-1:0] fwd_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[{wr_node, wr_lvl}] <= wr_data;
    end
    if (rd_en) begin
      q        <= mem[{rd_node, rd_lvl}];
      // the sentinel row is never written and always reads as zero
      zero     <= (rd_node == '0);
      fwd      <= wr_en && (wr_node == rd_node) && (wr_lvl == rd_lvl);
      fwd_data <= wr_data;
    end
  end

  assign rd_data = zero ? '0 : (fwd ? fwd_data : q);

endmodule

// ===== rtl/kajt_checker.sv =====
// port-level checker for the k-th ancestor jump table, bound to the top level
`include "kth_ancestor_jump_table_defines.svh"

module kajt_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // a query transaction keeps the block busy for its climb
  `KAJT_ASSERT_NEXT(a_query_busy, s_axis_tvalid && s_axis_tready && (s_axis_tuser == kajt_pkg::KIND_QUERY), !s_axis_tready, "input taken during a query climb")

  // present flag clearing runs right after reset
  `KAJT_ASSERT_SAME(a_clear_after_reset, $past(rst), !s_axis_tready, "input ready during clearing pass")

  `KAJT_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

endmodule

bind kth_ancestor_jump_table kajt_checker u_kajt_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
